FILE: sv/aff3_pkg.sv
// ----------------------------------------------------------------------------
// aff3_pkg
// Shared widths, index maps and queue/tag types for the 3x4 affine inverse.
// ----------------------------------------------------------------------------
package aff3_pkg;

    // matrix and arithmetic widths
    localparam int NUM_IN  = 12;
    localparam int NUM_COF = 9;
    localparam int NUM_ROW = 3;
    localparam int CW      = 65;   // signed cofactor
    localparam int CMW     = 64;   // cofactor magnitude
    localparam int PPW     = 65;   // 32 x 33 partial product
    localparam int TERM_W  = 97;   // 32 x 65 product
    localparam int DW      = 98;   // signed determinant / translation sum
    localparam int DMW     = 97;   // magnitude of the above

    // divider
    localparam int DIV_STEPS  = 32;
    localparam int DIV_STAGES = DIV_STEPS + 1;
    localparam logic [DIV_STEPS:0] SAT_POS = 33'h0_7FFF_FFFF;
    localparam logic [DIV_STEPS:0] SAT_NEG = 33'h0_8000_0000;

    // job queue
    localparam int QDEPTH = 2;

    // row codes
    localparam logic [1:0] ROW_0 = 2'd0;
    localparam logic [1:0] ROW_1 = 2'd1;
    localparam logic [1:0] ROW_2 = 2'd2;

    // configuration register byte address
    localparam logic [1:0] ADDR_THR = 2'd0;

    // cofactor k = m[p0]*m[p1] - m[p2]*m[p3], m indexed row*4+col
    localparam int COF_IDX [NUM_COF][4] = '{
        '{5, 10, 6, 9},
        '{2, 9, 1, 10},
        '{1, 6, 2, 5},
        '{6, 8, 4, 10},
        '{0, 10, 2, 8},
        '{2, 4, 0, 6},
        '{4, 9, 5, 8},
        '{1, 8, 0, 9},
        '{0, 5, 1, 4}
    };

    // linear row 0 and translation column carried past the cofactor stages
    localparam int X_IDX [6] = '{0, 1, 2, 3, 7, 11};

    typedef logic [NUM_IN-1:0][31:0] t_mat;

    // one classified matrix, ready for the divide lanes
    typedef struct packed {
        logic [DMW-1:0]                det_mag;
        logic                          det_neg;
        logic [NUM_COF-1:0][CMW-1:0]   cof_mag;
        logic [NUM_COF-1:0]            cof_neg;
        logic [NUM_ROW-1:0][DMW-1:0]   acc_mag;
        logic [NUM_ROW-1:0]            acc_neg;
        logic                          singular;
    } t_job;

    // row tag that travels beside the divide lanes
    typedef struct packed {
        logic [1:0] row;
        logic       singular;
    } t_tag;

endpackage

FILE: sv/affine_inverse_3x4_unit.sv
// ----------------------------------------------------------------------------
// affine_inverse_3x4_unit
// Inverse of a 3x4 affine matrix in signed fixed point, one row per result.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one matrix (i_a00..i_a23) per
// transfer. Result channel: o_valid / i_stall carry one row per transfer,
// rows 0, 1, 2 in order with o_last_row on row 2.
// The first row passes the front pipeline, the queue, the divide lanes and
// the output register; the other two follow on the next cycles when not
// stalled. The four divide lanes take one row per cycle when the result side
// does not stall, each a 33-stage pipeline: an input stage, then one quotient
// bit per stage. The front pipeline (8 stages) runs ahead into a 2-deep job
// queue, so input transfers continue while a finished row waits on the result
// side. A result-side stall holds the output row and the divide lanes; with
// the queue full and a job in the last front stage, o_stall rises at input.
// Reset (synchronous, active low) empties all pipelines and the queue and
// sets the singular threshold to 1. The threshold register lies at APB
// address 0; write it only while no matrix is in flight.
// ----------------------------------------------------------------------------
module affine_inverse_3x4_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // matrix in
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_a00,
    input  logic signed [31:0] i_a01,
    input  logic signed [31:0] i_a02,
    input  logic signed [31:0] i_a03,
    input  logic signed [31:0] i_a10,
    input  logic signed [31:0] i_a11,
    input  logic signed [31:0] i_a12,
    input  logic signed [31:0] i_a13,
    input  logic signed [31:0] i_a20,
    input  logic signed [31:0] i_a21,
    input  logic signed [31:0] i_a22,
    input  logic signed [31:0] i_a23,
    // rows out
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_singular,
    output logic               o_saturated,
    output logic               o_last_row
);
    import aff3_pkg::*;

    logic [30:0] r_thr;
    t_mat        w_mat;
    t_job        w_fjob;
    t_job        w_qjob;
    logic        w_push;
    logic        w_full;
    logic        w_qvld;
    logic        w_pop;

    // threshold register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_THR) ? {1'b0, r_thr} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 31'd1;
        end else if (psel && penable && pwrite && pready) begin
            r_thr <= pwdata[30:0];
        end
    end

    assign w_mat = {i_a23, i_a22, i_a21, i_a20, i_a13, i_a12, i_a11, i_a10,
                    i_a03, i_a02, i_a01, i_a00};

    aff3_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mat   (w_mat),
        .i_thr   (r_thr),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_fjob)
    );

    aff3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .o_vld   (w_qvld),
        .o_job   (w_qjob),
        .i_pop   (w_pop)
    );

    aff3_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_vld   (w_qvld),
        .i_job       (w_qjob),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_row_index (o_row_index),
        .o_col0      (o_col0),
        .o_col1      (o_col1),
        .o_col2      (o_col2),
        .o_col3      (o_col3),
        .o_singular  (o_singular),
        .o_saturated (o_saturated),
        .o_last_row  (o_last_row)
    );

`ifndef SYNTHESIS
    a_sing_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> !o_saturated && (o_col3 == '0))
        else $error("singular row carries saturation or translation");
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == ROW_2)))
        else $error("last row flag does not match row index");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row_index == ROW_0 || o_row_index == ROW_1 ||
                     o_row_index == ROW_2))
        else $error("row index out of range");
    a_row_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_row |=>
            o_valid && (o_row_index == $past(o_row_index) + 2'd1))
        else $error("rows of one matrix not back to back");
`endif

endmodule

FILE: sv/aff3_front.sv
// ----------------------------------------------------------------------------
// aff3_front
// Input pipeline: cofactors, determinant and translation sums computed
// exactly, then magnitudes and the singular decision, pushed to the queue.
// ----------------------------------------------------------------------------
module aff3_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  aff3_pkg::t_mat i_mat,
    input  logic [30:0]    i_thr,
    input  logic           i_full,
    output logic           o_push,
    output aff3_pkg::t_job o_job
);
    import aff3_pkg::*;

    localparam int NST  = 8;
    localparam int NJOB = 12;

    logic [NST-1:0]           r_vld;
    logic                     w_en;
    logic signed [31:0]       r_m0   [NUM_IN];
    logic signed [63:0]       r_pa1  [NUM_COF];
    logic signed [63:0]       r_pb1  [NUM_COF];
    logic signed [31:0]       r_x1   [6];
    logic signed [31:0]       r_x2   [6];
    logic signed [CW-1:0]     r_cof2 [NUM_COF];
    logic signed [CW-1:0]     r_cof3 [NUM_COF];
    logic signed [CW-1:0]     r_cof4 [NUM_COF];
    logic signed [CW-1:0]     r_cof5 [NUM_COF];
    logic signed [PPW-1:0]    r_plo3 [NJOB];
    logic signed [PPW-1:0]    r_phi3 [NJOB];
    logic signed [TERM_W-1:0] r_term4 [NJOB];
    logic signed [DW-1:0]     r_det5;
    logic signed [DW-1:0]     r_acc5 [NUM_ROW];
    logic [DMW-1:0]           r_dmag6;
    logic                     r_dneg6;
    logic [CMW-1:0]           r_cmag6 [NUM_COF];
    logic [NUM_COF-1:0]       r_cneg6;
    logic [DMW-1:0]           r_amag6 [NUM_ROW];
    logic [NUM_ROW-1:0]       r_aneg6;
    logic [DMW-1:0]           w_thr_sh;
    t_job                     r_job7;

    // whole pipeline moves unless the last stage is blocked by a full queue
    assign w_en    = !(r_vld[NST-1] && i_full);
    assign o_stall = !w_en;
    assign o_push  = r_vld[NST-1] && w_en;
    assign o_job   = r_job7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // capture, cofactor products, cofactors
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NUM_IN; i++) begin
                r_m0[i] <= i_mat[i];
            end
            for (int k = 0; k < NUM_COF; k++) begin
                r_pa1[k]  <= r_m0[COF_IDX[k][0]] * r_m0[COF_IDX[k][1]];
                r_pb1[k]  <= r_m0[COF_IDX[k][2]] * r_m0[COF_IDX[k][3]];
                r_cof2[k] <= CW'(r_pa1[k]) - CW'(r_pb1[k]);
                r_cof3[k] <= r_cof2[k];
                r_cof4[k] <= r_cof3[k];
                r_cof5[k] <= r_cof4[k];
            end
            for (int i = 0; i < 6; i++) begin
                r_x1[i] <= r_m0[X_IDX[i]];
                r_x2[i] <= r_x1[i];
            end
        end
    end

    // partial products: determinant terms first, then translation terms
    for (genvar jb = 0; jb < NJOB; jb++) begin : g_mul
        localparam int XI = (jb < 3) ? jb : 3 + ((jb - 3) % 3);
        localparam int CI = (jb < 3) ? 3 * jb : jb - 3;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_plo3[jb]  <= r_x2[XI] * $signed({1'b0, r_cof2[CI][31:0]});
                r_phi3[jb]  <= r_x2[XI] * $signed(r_cof2[CI][CW-1:32]);
                r_term4[jb] <= $signed({r_phi3[jb], 32'd0}) + TERM_W'(r_plo3[jb]);
            end
        end
    end

    // sums, magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_det5 <= DW'(r_term4[0]) + DW'(r_term4[1]) + DW'(r_term4[2]);
            for (int i = 0; i < NUM_ROW; i++) begin
                r_acc5[i] <= DW'(r_term4[3+3*i]) + DW'(r_term4[4+3*i])
                           + DW'(r_term4[5+3*i]);
            end
            r_dneg6 <= r_det5[DW-1];
            r_dmag6 <= r_det5[DW-1] ? DMW'(-r_det5) : DMW'(r_det5);
            for (int k = 0; k < NUM_COF; k++) begin
                r_cneg6[k] <= r_cof5[k][CW-1];
                r_cmag6[k] <= r_cof5[k][CW-1] ? CMW'(-r_cof5[k]) : CMW'(r_cof5[k]);
            end
            // translation numerator is minus the sum
            for (int i = 0; i < NUM_ROW; i++) begin
                r_aneg6[i] <= !r_acc5[i][DW-1] && (r_acc5[i] != '0);
                r_amag6[i] <= r_acc5[i][DW-1] ? DMW'(-r_acc5[i]) : DMW'(r_acc5[i]);
            end
        end
    end

    // singular decision against the shifted threshold
    assign w_thr_sh = DMW'(i_thr) << (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_job7.det_mag  <= r_dmag6;
            r_job7.det_neg  <= r_dneg6;
            r_job7.cof_neg  <= r_cneg6;
            r_job7.acc_neg  <= r_aneg6;
            r_job7.singular <= (r_dmag6 == '0) || (r_dmag6 < w_thr_sh);
            for (int k = 0; k < NUM_COF; k++) begin
                r_job7.cof_mag[k] <= r_cmag6[k];
            end
            for (int i = 0; i < NUM_ROW; i++) begin
                r_job7.acc_mag[i] <= r_amag6[i];
            end
        end
    end

endmodule

FILE: sv/aff3_queue.sv
// ----------------------------------------------------------------------------
// aff3_queue
// Short job queue between the front pipeline and the divide lanes.
// ----------------------------------------------------------------------------
module aff3_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  aff3_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_vld,
    output aff3_pkg::t_job o_job,
    input  logic           i_pop
);
    import aff3_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;

    assign o_full = (r_cnt == QCW'(QDEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_job  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + QCW'(i_push) - QCW'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("job queue pushed while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_vld)
        else $error("job queue popped while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QDEPTH))
        else $error("job queue count out of range");
`endif

endmodule

FILE: sv/aff3_div.sv
// ----------------------------------------------------------------------------
// aff3_div
// Pipelined restoring divider: an input stage, then one quotient bit per stage,
// 32-bit signed result truncated toward zero with saturation.
// ----------------------------------------------------------------------------
module aff3_div #(
    parameter int NW = 129,
    parameter int DW = 97
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic          i_neg,
    output logic [31:0]   o_quo,
    output logic          o_sat
);
    import aff3_pkg::*;

    localparam int HW = NW - DIV_STEPS;
    localparam int XW = (HW > DW) ? HW : DW;
    localparam int L  = DIV_STAGES - 1;

    logic [DW-1:0]        r_rem [DIV_STAGES];
    logic [DW-1:0]        r_den [DIV_STAGES];
    logic [DIV_STEPS-1:0] r_low [DIV_STAGES];
    logic [DIV_STEPS-1:0] r_quo [DIV_STAGES];
    logic                 r_neg [DIV_STAGES];
    logic                 r_ovf [DIV_STAGES];
    logic [XW-1:0]        w_hi;
    logic [XW-1:0]        w_dx;
    logic [DIV_STEPS:0]   w_lim;
    logic                 w_sat;
    logic [31:0]          w_mag;

    // quotient needs more than 32 bits when the upper part reaches the divisor
    assign w_hi = XW'(i_num[NW-1:DIV_STEPS]);
    assign w_dx = XW'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(w_hi);
            r_den[0] <= i_den;
            r_low[0] <= i_num[DIV_STEPS-1:0];
            r_quo[0] <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= (w_hi >= w_dx);
        end
    end

    // one trial subtract per stage
    for (genvar s = 1; s < DIV_STAGES; s++) begin : g_step
        logic [DW:0] w_try;
        logic        w_ge;

        assign w_try = {r_rem[s-1], r_low[s-1][DIV_STEPS-1]};
        assign w_ge  = (w_try >= {1'b0, r_den[s-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? DW'(w_try - {1'b0, r_den[s-1]}) : DW'(w_try);
                r_den[s] <= r_den[s-1];
                r_low[s] <= r_low[s-1] << 1;
                r_quo[s] <= {r_quo[s-1][DIV_STEPS-2:0], w_ge};
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    // clamp and apply the sign
    assign w_lim = r_neg[L] ? SAT_NEG : SAT_POS;
    assign w_sat = r_ovf[L] || ({1'b0, r_quo[L]} > w_lim);
    assign w_mag = w_sat ? w_lim[31:0] : r_quo[L];
    assign o_quo = r_neg[L] ? (~w_mag + 32'd1) : w_mag;
    assign o_sat = w_sat;

endmodule

FILE: sv/aff3_back.sv
// ----------------------------------------------------------------------------
// aff3_back
// Issues the three rows of a queued job into four divide lanes, one row per
// cycle unless the result channel stalls, and registers each finished row.
// ----------------------------------------------------------------------------
module aff3_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_vld,
    input  aff3_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_singular,
    output logic               o_saturated,
    output logic               o_last_row
);
    import aff3_pkg::*;

    localparam int NW    = DMW + 2 * FRAC_BITS;
    localparam int LANES = 4;
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic                         w_en;
    logic [1:0]                   r_row;
    logic [DIV_STAGES-1:0]        r_vld;
    t_tag                         r_tag [DIV_STAGES];
    logic [CMW-1:0]               w_cmag [NUM_ROW];
    logic [NUM_ROW-1:0]           w_cneg;
    logic [DMW-1:0]               w_amag;
    logic                         w_aneg;
    logic [LANES-1:0][NW-1:0]     w_num;
    logic [LANES-1:0]             w_neg;
    logic [LANES-1:0][31:0]       w_quo;
    logic [LANES-1:0]             w_sat;
    logic                         r_out_vld;
    logic [1:0]                   r_out_row;
    logic [LANES-1:0][31:0]       r_out_col;
    logic                         r_out_sing;
    logic                         r_out_sat;
    logic                         r_out_last;

    // lanes and output register move together
    assign w_en  = !r_out_vld || !i_stall;
    assign o_pop = i_job_vld && w_en && (r_row == ROW_2);

    // row counter over the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= ROW_0;
        end else if (w_en && i_job_vld) begin
            r_row <= (r_row == ROW_2) ? ROW_0 : r_row + 2'd1;
        end
    end

    // pick this row's cofactors and translation sum
    always_comb begin
        w_amag = '0;
        w_aneg = 1'b0;
        for (int j = 0; j < NUM_ROW; j++) begin
            w_cmag[j] = '0;
            w_cneg[j] = 1'b0;
        end
        unique case (r_row)
            ROW_0: begin
                for (int j = 0; j < NUM_ROW; j++) begin
                    w_cmag[j] = i_job.cof_mag[j];
                    w_cneg[j] = i_job.cof_neg[j];
                end
                w_amag = i_job.acc_mag[0];
                w_aneg = i_job.acc_neg[0];
            end
            ROW_1: begin
                for (int j = 0; j < NUM_ROW; j++) begin
                    w_cmag[j] = i_job.cof_mag[3+j];
                    w_cneg[j] = i_job.cof_neg[3+j];
                end
                w_amag = i_job.acc_mag[1];
                w_aneg = i_job.acc_neg[1];
            end
            ROW_2: begin
                for (int j = 0; j < NUM_ROW; j++) begin
                    w_cmag[j] = i_job.cof_mag[6+j];
                    w_cneg[j] = i_job.cof_neg[6+j];
                end
                w_amag = i_job.acc_mag[2];
                w_aneg = i_job.acc_neg[2];
            end
            default: begin
                w_amag = '0;
            end
        endcase
    end

    // scaled numerators and quotient signs
    always_comb begin
        for (int j = 0; j < NUM_ROW; j++) begin
            w_num[j] = NW'(w_cmag[j]) << (2 * FRAC_BITS);
            w_neg[j] = w_cneg[j] ^ i_job.det_neg;
        end
        w_num[3] = NW'(w_amag) << FRAC_BITS;
        w_neg[3] = w_aneg ^ i_job.det_neg;
    end

    for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
        aff3_div #(
            .NW (NW),
            .DW (DMW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[ln]),
            .i_den (i_job.det_mag),
            .i_neg (w_neg[ln]),
            .o_quo (w_quo[ln]),
            .o_sat (w_sat[ln])
        );
    end

    // valid and row tag beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_job_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tag[0] <= '{row: r_row, singular: i_job.singular};
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    // output register, identity row on a singular matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_row  <= r_tag[DIV_STAGES-1].row;
            r_out_sing <= r_tag[DIV_STAGES-1].singular;
            r_out_last <= (r_tag[DIV_STAGES-1].row == ROW_2);
            if (r_tag[DIV_STAGES-1].singular) begin
                for (int j = 0; j < NUM_ROW; j++) begin
                    r_out_col[j] <= (2'(j) == r_tag[DIV_STAGES-1].row) ? ONE : '0;
                end
                r_out_col[3] <= '0;
                r_out_sat    <= 1'b0;
            end else begin
                r_out_col <= w_quo;
                r_out_sat <= |w_sat;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_row_index = r_out_row;
    assign o_col0      = r_out_col[0];
    assign o_col1      = r_out_col[1];
    assign o_col2      = r_out_col[2];
    assign o_col3      = r_out_col[3];
    assign o_singular  = r_out_sing;
    assign o_saturated = r_out_sat;
    assign o_last_row  = r_out_last;

endmodule

FILE: tb/sv/affine_inverse_3x4_unit_tb.sv
// ----------------------------------------------------------------------------
// affine_inverse_3x4_unit_tb
// Drives 3x4 affine matrices into the inverse unit and checks every row that
// comes out against an exact wide-integer model of cofactors, determinant,
// truncating division and saturation. Covers directed corner matrices,
// random well-conditioned and noisy matrices, several singular thresholds,
// random idling on both sides and a long hold-off on the result side.
// ----------------------------------------------------------------------------
module affine_inverse_3x4_unit_tb;
    import aff3_pkg::*;

    localparam int FB = 16;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] c0, c1, c2, c3;
        logic               sing, sat, last;
    } t_row;

    // expected rows of the inverse, oldest first
    class inverse_board;
        t_row          rows_due[$];
        logic [30:0]   thr;
        int            errors;
        int            rows_seen;
        int            sing_seen;
        int            sat_seen;

        function new();
            thr = 31'd1;
            errors = 0;
            rows_seen = 0;
            sing_seen = 0;
            sat_seen = 0;
        endfunction

        // truncating signed divide with 32-bit clamp
        function logic signed [31:0] div_clamp(
            logic signed [191:0] num, logic signed [191:0] den, ref logic sat);
            logic signed [191:0] q;
            q = num / den;
            if (q > 192'sd2147483647) begin
                sat = 1'b1;
                return 32'sh7FFFFFFF;
            end
            if (q < -192'sd2147483648) begin
                sat = 1'b1;
                return 32'sh80000000;
            end
            return q[31:0];
        endfunction

        function void note_matrix(logic signed [31:0] m[12]);
            logic signed [191:0] w[12];
            logic signed [191:0] cof[9];
            logic signed [191:0] det, acc;
            logic                is_sing, sat;
            logic signed [31:0]  v[4];
            t_row                r;
            for (int i = 0; i < 12; i++) w[i] = 192'(m[i]);
            cof[0] = w[5]*w[10] - w[6]*w[9];
            cof[1] = w[2]*w[9]  - w[1]*w[10];
            cof[2] = w[1]*w[6]  - w[2]*w[5];
            cof[3] = w[6]*w[8]  - w[4]*w[10];
            cof[4] = w[0]*w[10] - w[2]*w[8];
            cof[5] = w[2]*w[4]  - w[0]*w[6];
            cof[6] = w[4]*w[9]  - w[5]*w[8];
            cof[7] = w[1]*w[8]  - w[0]*w[9];
            cof[8] = w[0]*w[5]  - w[1]*w[4];
            det = w[0]*cof[0] + w[1]*cof[3] + w[2]*cof[6];
            is_sing = (det == 0) ||
                ((det < 0 ? -det : det) < ($signed({161'd0, thr}) <<< (2*FB)));
            if (is_sing) sing_seen++;
            for (int i = 0; i < 3; i++) begin
                sat = 1'b0;
                if (is_sing) begin
                    for (int j = 0; j < 3; j++) v[j] = (i == j) ? 32'sd65536 : 32'sd0;
                    v[3] = 0;
                end else begin
                    acc = 0;
                    for (int j = 0; j < 3; j++) begin
                        v[j] = div_clamp(cof[i*3+j] <<< (2*FB), det, sat);
                        acc = acc + cof[i*3+j] * w[j*4+3];
                    end
                    v[3] = div_clamp((-acc) <<< FB, det, sat);
                end
                if (sat) sat_seen++;
                r.row = i[1:0];
                r.c0 = v[0]; r.c1 = v[1]; r.c2 = v[2]; r.c3 = v[3];
                r.sing = is_sing; r.sat = sat; r.last = (i == 2);
                rows_due.push_back(r);
            end
        endfunction

        function void check_row(t_row got);
            t_row exp_r;
            rows_seen++;
            if (rows_due.size() == 0) begin
                $error("row with no matrix pending: row_index %0d", got.row);
                errors++;
                return;
            end
            exp_r = rows_due.pop_front();
            if (got.row != exp_r.row) begin
                $error("row_index exp %0d got %0d", exp_r.row, got.row); errors++;
            end
            if (got.c0 != exp_r.c0) begin
                $error("col0 exp %h got %h", exp_r.c0, got.c0); errors++;
            end
            if (got.c1 != exp_r.c1) begin
                $error("col1 exp %h got %h", exp_r.c1, got.c1); errors++;
            end
            if (got.c2 != exp_r.c2) begin
                $error("col2 exp %h got %h", exp_r.c2, got.c2); errors++;
            end
            if (got.c3 != exp_r.c3) begin
                $error("col3 exp %h got %h", exp_r.c3, got.c3); errors++;
            end
            if (got.sing != exp_r.sing) begin
                $error("singular exp %0b got %0b", exp_r.sing, got.sing); errors++;
            end
            if (got.sat != exp_r.sat) begin
                $error("saturated exp %0b got %0b", exp_r.sat, got.sat); errors++;
            end
            if (got.last != exp_r.last) begin
                $error("last_row exp %0b got %0b", exp_r.last, got.last); errors++;
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n;
    logic               psel, penable, pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    logic               i_valid, o_stall, o_valid, i_stall;
    logic signed [31:0] a[12];
    logic [1:0]         o_row_index;
    logic signed [31:0] o_col0, o_col1, o_col2, o_col3;
    logic               o_singular, o_saturated, o_last_row;

    inverse_board board;
    bit           idle_off;
    bit           hold_req;
    int           matrices_sent;

    affine_inverse_3x4_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_a00(a[0]), .i_a01(a[1]), .i_a02(a[2]), .i_a03(a[3]),
        .i_a10(a[4]), .i_a11(a[5]), .i_a12(a[6]), .i_a13(a[7]),
        .i_a20(a[8]), .i_a21(a[9]), .i_a22(a[10]), .i_a23(a[11]),
        .o_valid(o_valid), .i_stall(i_stall), .o_row_index(o_row_index),
        .o_col0(o_col0), .o_col1(o_col1), .o_col2(o_col2), .o_col3(o_col3),
        .o_singular(o_singular), .o_saturated(o_saturated), .o_last_row(o_last_row)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: sample rows at the rising edge
    always @(posedge i_clk) begin
        t_row got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.row = o_row_index;
            got.c0 = o_col0; got.c1 = o_col1; got.c2 = o_col2; got.c3 = o_col3;
            got.sing = o_singular; got.sat = o_saturated; got.last = o_last_row;
            board.check_row(got);
        end
    end

    // result side stall: random bursts, long hold-off on request
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                for (int k = 0; k < 120; k++) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 16);
                i_stall <= 1'b1;
                for (int k = 1; k < n; k++) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic apb_write(logic [30:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_THR; pwdata <= {1'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.thr = value;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // one matrix transfer, with an optional random gap first
    task automatic send_matrix(logic signed [31:0] m[12]);
        int gap;
        if (!idle_off && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        for (int i = 0; i < 12; i++) a[i] <= m[i];
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_matrix(m);
        matrices_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.rows_due.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rnd32();
        return $urandom;
    endfunction

    // random matrices: mode 0 fully random, else diagonal-dominant entries around 1.0 scaled
    task automatic send_random(int mode);
        logic signed [31:0] m[12];
        int sh;
        sh = $urandom_range(0, 14);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (mode == 0) m[r*4+c] = rnd32();
                else if (c == 3) m[r*4+c] = $signed($urandom) >>> $urandom_range(0, 20);
                else if (r == c)
                    m[r*4+c] = ($urandom_range(0, 1) ? 1 : -1) *
                               ($signed(32'h10000 + $urandom_range(0, 32'h3FFFF)) >>> (sh / 2));
                else m[r*4+c] = $signed($urandom) >>> (16 + $urandom_range(0, 15));
            end
        end
        // occasionally make a row a copy of another: exactly singular
        if (mode == 2) for (int c = 0; c < 3; c++) m[8+c] = m[c];
        send_matrix(m);
    endtask

    task automatic send_ident(logic signed [31:0] d0, logic signed [31:0] d1,
                              logic signed [31:0] d2, logic signed [31:0] t);
        logic signed [31:0] m[12];
        for (int i = 0; i < 12; i++) m[i] = 0;
        m[0] = d0; m[5] = d1; m[10] = d2; m[3] = t; m[7] = -t; m[11] = t;
        send_matrix(m);
    endtask

    // stimulus
    initial begin
        logic signed [31:0] m[12];
        board = new();
        idle_off = 1'b0;
        hold_req = 1'b0;
        matrices_sent = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = ADDR_THR; pwdata = '0;
        i_valid = 1'b0;
        for (int i = 0; i < 12; i++) a[i] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners at reset threshold
        send_ident(32'sh10000, 32'sh10000, 32'sh10000, 32'sh7FFFFFFF);
        send_ident(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_ident(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_ident(1, 1, 1, 32'sh7FFFFFFF);          // tiny det: singular
        send_ident(32'sh100, 32'sh100, 32'sh100, 32'sh10000); // det 2^-24, under threshold: singular
        send_ident(32'sh10, 32'sh10000, 32'sh10000, 32'sh7FFFFFFF); // clamps
        send_ident(-32'sh10, 32'sh10000, 32'sh10000, 32'sh7FFFFFFF);
        send_ident(0, 0, 0, 0);                      // zero determinant
        for (int i = 0; i < 12; i++) m[i] = 32'shFFFFFFFF;
        send_matrix(m);
        for (int i = 0; i < 12; i++) m[i] = 32'sh80000000;
        send_matrix(m);
        for (int i = 0; i < 12; i++) m[i] = (i % 5 == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
        send_matrix(m);
        // permutation matrix with negative scale
        for (int i = 0; i < 12; i++) m[i] = 0;
        m[1] = -32'sh20000; m[6] = 32'sh8000; m[8] = 32'sh10000;
        m[3] = 32'sh12345; m[7] = -32'sh54321; m[11] = 32'sh1;
        send_matrix(m);
        drain();

        // threshold zero: only exact zero counts as singular
        apb_write(31'd0);
        send_ident(0, 32'sh10000, 32'sh10000, 5);
        send_ident(1, 1, 1, 1);
        for (int k = 0; k < 60; k++) send_random($urandom_range(0, 2));
        drain();

        // largest threshold: scaled random matrices singular, full-scale ones not
        apb_write(31'h7FFFFFFF);
        send_ident(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
        for (int k = 0; k < 30; k++) send_random($urandom_range(0, 1));
        drain();

        // mid thresholds, with one long result-side hold-off
        apb_write(31'h8000);
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++) send_random($urandom_range(0, 4) == 0 ? 0 : 1);
        drain();
        apb_write(31'($urandom_range(1, 32'h40000)));
        for (int k = 0; k < 80; k++)
            send_random($urandom_range(0, 9) == 0 ? 2 : ($urandom_range(0, 3) == 0 ? 0 : 1));
        drain();

        // back to default, no idling at the end
        apb_write(31'd1);
        for (int k = 0; k < 40; k++) send_random($urandom_range(0, 2));
        idle_off = 1'b1;
        for (int k = 0; k < 80; k++) send_random($urandom_range(0, 3) == 0 ? 0 : 1);
        drain();

        $display("covered %0d matrices, %0d rows checked, %0d singular, %0d clamped rows",
                 matrices_sent, board.rows_seen, board.sing_seen, board.sat_seen);
        $display("thresholds 0, 1, 0x8000, random and 0x7FFFFFFF; long result hold-off");
        if (board.errors == 0 && board.rows_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
